// ===== rtl/pts_pkg.sv =====
// Shared types and constants for the periodic task scheduler.
// No dependencies; used by pts_core and periodic_task_scheduler_unit.
package pts_pkg;

  // configuration register file
  localparam int CFG_W      = 48;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_POLICY  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIODS = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BURSTS  = 2'd3;

  localparam logic             RST_POLICY  = 1'b1;
  localparam logic [2:0]       RST_COUNT   = 3'd2;
  localparam logic [CFG_W-1:0] RST_PERIODS = 48'd327730;
  localparam logic [CFG_W-1:0] RST_BURSTS  = 48'd143385;

  localparam logic POLICY_RM  = 1'b0;
  localparam logic POLICY_EDF = 1'b1;

  // result fields
  localparam int COUNT_W = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int TIDX_W = 2;
  localparam int MISS_W = 4;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  typedef struct packed {
    logic              busy;
    logic              finished;
    logic              preempted;
    logic [TIDX_W-1:0] task_index;
    logic [TIDX_W-1:0] preempted_task;
    logic [MISS_W-1:0] missed_mask;
    logic              has_summary;
  } tick_rpt_t;

endpackage

// ===== rtl/pts_core.sv =====
// Scheduler core: configuration registers, per-task state and the one-tick update.
// Depends on pts_pkg.
module pts_core #(
  parameter int NUM_TASKS = 4,
  parameter int TIME_BITS = 12,
  parameter int IDX_W     = 2,
  parameter int CNT_W     = 3
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_we,
  input  logic [pts_pkg::CFG_ADDR_W-1:0]              cfg_addr,
  input  logic [pts_pkg::CFG_W-1:0]                   cfg_wdata,
  input  logic                                        tick,
  input  logic                                        restart,
  input  logic                                        final_tick,
  output pts_pkg::tick_rpt_t                          rpt,
  output logic [CNT_W-1:0]                            active_n,
  output logic [NUM_TASKS-1:0][pts_pkg::COUNT_W-1:0]  lost_cnt,
  output logic [NUM_TASKS-1:0][pts_pkg::COUNT_W-1:0]  comp_cnt,
  output logic [NUM_TASKS-1:0][pts_pkg::COUNT_W-1:0]  kill_cnt
);

  typedef logic [TIME_BITS-1:0]        time_t;
  typedef logic [pts_pkg::COUNT_W-1:0] cnt_t;

  localparam time_t TIME_MAX = '1;

  function automatic time_t field_of(input logic [pts_pkg::CFG_W-1:0] packed_v,
                                     input int idx);
    logic [pts_pkg::CFG_W-1:0] sh;
    sh = packed_v >> (idx * TIME_BITS);
    return sh[TIME_BITS-1:0];
  endfunction

  function automatic time_t period_fix(input time_t p);
    return (p == '0) ? time_t'(1) : p;
  endfunction

  function automatic cnt_t cnt_inc(input cnt_t v);
    return (v == pts_pkg::COUNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  // configuration
  logic                      policy_mode;
  logic [2:0]                task_count;
  logic [pts_pkg::CFG_W-1:0] task_periods;
  logic [pts_pkg::CFG_W-1:0] task_bursts;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode  <= pts_pkg::RST_POLICY;
      task_count   <= pts_pkg::RST_COUNT;
      task_periods <= pts_pkg::RST_PERIODS;
      task_bursts  <= pts_pkg::RST_BURSTS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pts_pkg::REG_POLICY:  policy_mode  <= cfg_wdata[0];
        pts_pkg::REG_COUNT:   task_count   <= cfg_wdata[2:0];
        pts_pkg::REG_PERIODS: task_periods <= cfg_wdata;
        pts_pkg::REG_BURSTS:  task_bursts  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // task state
  time_t            rem [NUM_TASKS];
  time_t            elapsed [NUM_TASKS];
  time_t            countdown [NUM_TASKS];
  cnt_t             lost [NUM_TASKS];
  cnt_t             comp [NUM_TASKS];
  cnt_t             kill [NUM_TASKS];
  logic             prev_valid;
  logic [IDX_W-1:0] prev_task;

  time_t            rem_next [NUM_TASKS];
  time_t            elapsed_next [NUM_TASKS];
  time_t            countdown_next [NUM_TASKS];
  cnt_t             lost_next [NUM_TASKS];
  cnt_t             comp_next [NUM_TASKS];
  cnt_t             kill_next [NUM_TASKS];
  logic             prev_valid_next;
  logic [IDX_W-1:0] prev_task_next;

  // state as seen by this tick (restart applied first)
  time_t            per [NUM_TASKS];
  time_t            burst [NUM_TASKS];
  time_t            e_rem [NUM_TASKS];
  time_t            e_el [NUM_TASKS];
  time_t            e_cd [NUM_TASKS];
  cnt_t             e_lost [NUM_TASKS];
  cnt_t             e_comp [NUM_TASKS];
  cnt_t             e_kill [NUM_TASKS];
  logic             e_pv;
  logic [IDX_W-1:0] e_prev;
  logic [NUM_TASKS-1:0] act;

  logic             busy;
  logic [IDX_W-1:0] best;
  time_t            best_key;
  logic             pre;
  logic             fin;
  logic [NUM_TASKS-1:0] missed;
  logic [NUM_TASKS+pts_pkg::MISS_W-1:0] missed_ext;
  logic [IDX_W+pts_pkg::TIDX_W-1:0]     best_ext;
  logic [IDX_W+pts_pkg::TIDX_W-1:0]     pre_ext;

  always_comb begin
    if (int'(task_count) > NUM_TASKS) begin
      active_n = CNT_W'(NUM_TASKS);
    end else begin
      active_n = CNT_W'(task_count);
    end
    for (int i = 0; i < NUM_TASKS; i++) begin
      act[i]   = int'(active_n) > i;
      per[i]   = period_fix(field_of(task_periods, i));
      burst[i] = field_of(task_bursts, i);
      if (restart) begin
        e_rem[i]  = burst[i];
        e_el[i]   = '0;
        e_cd[i]   = per[i];
        e_lost[i] = '0;
        e_comp[i] = '0;
        e_kill[i] = '0;
      end else begin
        e_rem[i]  = rem[i];
        e_el[i]   = elapsed[i];
        e_cd[i]   = countdown[i];
        e_lost[i] = lost[i];
        e_comp[i] = comp[i];
        e_kill[i] = kill[i];
      end
    end
    e_pv   = restart ? 1'b0 : prev_valid;
    e_prev = restart ? '0 : prev_task;
  end

  // selection: lowest key among ready tasks, ties to the lowest index
  always_comb begin
    time_t key;
    busy     = 1'b0;
    best     = '0;
    best_key = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (policy_mode == pts_pkg::POLICY_EDF) begin
        key = (e_el[i] >= per[i]) ? '0 : per[i] - e_el[i];
      end else begin
        key = per[i];
      end
      if (act[i] && e_rem[i] != '0 && (!busy || key < best_key)) begin
        busy     = 1'b1;
        best     = IDX_W'(i);
        best_key = key;
      end
    end
    pre = e_pv && (int'(e_prev) < int'(active_n)) && (!busy || e_prev != best) &&
          (e_rem[e_prev] != '0);
    fin = busy && (e_rem[best] == time_t'(1));
  end

  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      rem_next[i]       = e_rem[i];
      elapsed_next[i]   = e_el[i];
      countdown_next[i] = e_cd[i];
      lost_next[i]      = e_lost[i];
      comp_next[i]      = e_comp[i];
      kill_next[i]      = e_kill[i];
      missed[i]         = 1'b0;
      if (busy && best == IDX_W'(i)) begin
        rem_next[i] = e_rem[i] - time_t'(1);
        if (e_rem[i] == time_t'(1)) begin
          comp_next[i] = cnt_inc(e_comp[i]);
        end
      end
      if (act[i]) begin
        elapsed_next[i]   = (e_el[i] == TIME_MAX) ? e_el[i] : e_el[i] + time_t'(1);
        countdown_next[i] = (e_cd[i] != '0) ? e_cd[i] - time_t'(1) : '0;
        // period boundary: count a miss on leftover work, then release
        if (countdown_next[i] == '0) begin
          if (rem_next[i] != '0) begin
            lost_next[i] = cnt_inc(e_lost[i]);
            missed[i]    = 1'b1;
          end
          rem_next[i]       = burst[i];
          elapsed_next[i]   = '0;
          countdown_next[i] = per[i];
        end
        if (final_tick && busy && rem_next[i] >= time_t'(2)) begin
          kill_next[i] = cnt_inc(e_kill[i]);
        end
      end
    end
    prev_valid_next = busy;
    prev_task_next  = busy ? best : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        rem[i]       <= field_of(pts_pkg::RST_BURSTS, i);
        elapsed[i]   <= '0;
        countdown[i] <= period_fix(field_of(pts_pkg::RST_PERIODS, i));
        lost[i]      <= '0;
        comp[i]      <= '0;
        kill[i]      <= '0;
      end
      prev_valid <= 1'b0;
      prev_task  <= '0;
    end else if (tick) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        rem[i]       <= rem_next[i];
        elapsed[i]   <= elapsed_next[i];
        countdown[i] <= countdown_next[i];
        lost[i]      <= lost_next[i];
        comp[i]      <= comp_next[i];
        kill[i]      <= kill_next[i];
      end
      prev_valid <= prev_valid_next;
      prev_task  <= prev_task_next;
    end
  end

  always_comb begin
    missed_ext = {{pts_pkg::MISS_W{1'b0}}, missed};
    best_ext   = {{pts_pkg::TIDX_W{1'b0}}, busy ? best : {IDX_W{1'b0}}};
    pre_ext    = {{pts_pkg::TIDX_W{1'b0}}, pre ? e_prev : {IDX_W{1'b0}}};
    rpt.busy           = busy;
    rpt.finished       = fin;
    rpt.preempted      = pre;
    rpt.task_index     = best_ext[pts_pkg::TIDX_W-1:0];
    rpt.preempted_task = pre_ext[pts_pkg::TIDX_W-1:0];
    rpt.missed_mask    = missed_ext[pts_pkg::MISS_W-1:0];
    rpt.has_summary    = final_tick && (active_n != '0);
    for (int i = 0; i < NUM_TASKS; i++) begin
      lost_cnt[i] = lost[i];
      comp_cnt[i] = comp[i];
      kill_cnt[i] = kill[i];
    end
  end

endmodule

// ===== rtl/periodic_task_scheduler_unit.sv =====
// Periodic task scheduler (rate monotonic / EDF), top level with result sequencing.
// Depends on pts_pkg and pts_core.
//
// Usage: each transfer on the s_ channel is one timer tick. s_tdata[0] is restart
// (reload all task state from the configuration before this tick), s_tlast marks the
// final tick. Each tick yields a tick report (m_tuser = 0) naming the task that ran.
// On a final tick with active tasks, one summary per active task follows
// (m_tuser = 1) with its lost, completed and killed counts; m_tlast marks the
// last result of a tick.
// A tick's report is registered and valid in the cycle after its transfer.
// Throughput: one tick per cycle while m_tready stays high; a final tick holds
// s_tready low while its summaries, one per active task, pass through the single
// result register that they share with the tick reports. Reset: rst (synchronous)
// restores the configuration defaults (EDF, two tasks), reloads task state and
// empties the result register. Stall: with m_tready low the result register
// holds; s_tready drops only while a result is held, so one tick may be taken
// while the previous result is drained. Configuration (cfg_we/cfg_addr/cfg_wdata)
// is the user's to write only while the block is idle; not enforced by the block.
module periodic_task_scheduler_unit #(
  parameter int NUM_TASKS = 4,
  parameter int TIME_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pts_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pts_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pts_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] restart, rest zero
  input  logic                              s_tlast,   // final_tick
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [1:0] task_index, [2] busy_res, [3] finished, [4] preempted,
  // [6:5] preempted_task, [10:7] missed_mask, [22:11] lost_count,
  // [34:23] completed_count, [46:35] killed_count, [47] zero
  output logic [pts_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tuser,   // report_kind
  output logic                              m_tlast    // last
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);

  pts_pkg::tick_rpt_t                         rpt;
  logic [CNT_W-1:0]                           active_n;
  logic [NUM_TASKS-1:0][pts_pkg::COUNT_W-1:0] lost_cnt;
  logic [NUM_TASKS-1:0][pts_pkg::COUNT_W-1:0] comp_cnt;
  logic [NUM_TASKS-1:0][pts_pkg::COUNT_W-1:0] kill_cnt;

  logic             tick;
  logic             load_ok;
  logic             sum_active;
  logic [CNT_W-1:0] sum_idx;
  logic [CNT_W-1:0] sum_n;
  logic [IDX_W-1:0] sum_sel;
  logic             sum_last;
  logic [CNT_W+pts_pkg::TIDX_W-1:0] sum_idx_ext;

  assign load_ok  = !m_tvalid || m_tready;
  assign s_tready = load_ok && !sum_active;
  assign tick     = s_tvalid && s_tready;
  assign sum_sel  = sum_idx[IDX_W-1:0];
  assign sum_last = (sum_idx == sum_n - CNT_W'(1));
  assign sum_idx_ext = {{pts_pkg::TIDX_W{1'b0}}, sum_idx};

  pts_core #(
    .NUM_TASKS (NUM_TASKS),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .tick       (tick),
    .restart    (s_tdata[0]),
    .final_tick (s_tlast),
    .rpt        (rpt),
    .active_n   (active_n),
    .lost_cnt   (lost_cnt),
    .comp_cnt   (comp_cnt),
    .kill_cnt   (kill_cnt)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      sum_active <= 1'b0;
      sum_idx    <= '0;
      sum_n      <= '0;
    end else if (tick) begin
      m_tvalid   <= 1'b1;
      sum_active <= rpt.has_summary;
      sum_idx    <= '0;
      sum_n      <= active_n;
    end else if (load_ok && sum_active) begin
      m_tvalid   <= 1'b1;
      sum_idx    <= sum_idx + CNT_W'(1);
      sum_active <= !sum_last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload; summaries read counters frozen while input is held off
  always_ff @(posedge clk) begin
    if (tick) begin
      m_tuser <= pts_pkg::KIND_TICK;
      m_tlast <= !rpt.has_summary;
      m_tdata <= {1'b0,
                  {pts_pkg::COUNT_W{1'b0}},
                  {pts_pkg::COUNT_W{1'b0}},
                  {pts_pkg::COUNT_W{1'b0}},
                  rpt.missed_mask,
                  rpt.preempted_task,
                  rpt.preempted,
                  rpt.finished,
                  rpt.busy,
                  rpt.task_index};
    end else if (load_ok && sum_active) begin
      m_tuser <= pts_pkg::KIND_SUMMARY;
      m_tlast <= sum_last;
      m_tdata <= {1'b0,
                  kill_cnt[sum_sel],
                  comp_cnt[sum_sel],
                  lost_cnt[sum_sel],
                  {pts_pkg::MISS_W{1'b0}},
                  {pts_pkg::TIDX_W{1'b0}},
                  1'b0,
                  1'b0,
                  1'b0,
                  sum_idx_ext[pts_pkg::TIDX_W-1:0]};
    end
  end

  // a summary run always has a result on the port
  a_sum_has_output: assert property (@(posedge clk) disable iff (rst)
    sum_active |-> m_tvalid)
    else $error("summary pending without a held result");

  // a non-final result is always followed by another
  a_follow_up: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("result run ended without tlast");

  // completion only on a tick where a task ran
  a_fin_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == pts_pkg::KIND_TICK && m_tdata[3] |-> m_tdata[2])
    else $error("finished flagged on an idle tick");

  // the displaced task is never the one that ran
  a_pre_diff: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == pts_pkg::KIND_TICK && m_tdata[4] && m_tdata[2] &&
    NUM_TASKS <= 4 |-> m_tdata[6:5] != m_tdata[1:0])
    else $error("preempted task equals running task");

  // no tick is taken while summaries are still going out
  a_no_tick_in_sum: assert property (@(posedge clk) disable iff (rst)
    sum_active |-> !tick)
    else $error("tick accepted during summary output");

endmodule
